/* hw/rtl/gne_pkg.sv */
// ----------------------------------------------------------------------------
// gne_pkg: shared types and constants of the grid neighbor expander
// Item structs, configuration codes, controller states and the neighbor
// offset table used by the controller and the datapath.
// ----------------------------------------------------------------------------
package gne_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_AW   = $clog2(MAX_ROWS);
  localparam int COL_AW   = $clog2(MAX_COLS);

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 7;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_EXPAND = 1'b1;

  localparam logic HMODE_MANHATTAN = 1'b0;
  localparam logic HMODE_OCTILE    = 1'b1;

  localparam logic [2:0] COST_ORTHO = 3'd5;
  localparam logic [2:0] COST_DIAG  = 3'd7;

  typedef enum logic [CFG_AW-1:0] {
    CFG_GRID_ROWS = 3'd0,
    CFG_GRID_COLS = 3'd1,
    CFG_EXIT_ROW  = 3'd2,
    CFG_EXIT_COL  = 3'd3,
    CFG_HMODE     = 3'd4
  } cfg_reg_t;

  // Offset codes: minus one, zero, plus one.
  localparam logic [1:0] OFS_NEG  = 2'b11;
  localparam logic [1:0] OFS_ZERO = 2'b00;
  localparam logic [1:0] OFS_POS  = 2'b01;

  typedef struct packed {
    logic       func;
    logic [5:0] cell_row;
    logic [5:0] cell_col;
    logic       blocked;
  } in_item_t;

  typedef struct packed {
    logic [5:0] nbr_row;
    logic [5:0] nbr_col;
    logic [2:0] move_cost;
    logic [8:0] heuristic;
    logic       found;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR_RD,
    ST_WR_WB,
    ST_RD_UP,
    ST_RD_MID,
    ST_RD_DN,
    ST_MASK,
    ST_EMIT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    SEL_UP,
    SEL_MID,
    SEL_DN
  } row_sel_t;

  typedef struct packed {
    logic     load_item;
    row_sel_t rd_sel;
    logic     wr_en;
    logic     cap_up;
    logic     cap_mid;
    logic     build_mask;
    logic     emit;
  } dp_cmd_t;

  typedef struct packed {
    logic func;
    logic out_can_load;
    logic emit_last;
  } dp_status_t;

  // Neighbors are visited row by row from the upper left.
  function automatic logic [1:0] dir_dr(input logic [2:0] k);
    logic [1:0] d;
    unique case (k)
      3'd0, 3'd1, 3'd2: d = OFS_NEG;
      3'd3, 3'd4:       d = OFS_ZERO;
      default:          d = OFS_POS;
    endcase
    return d;
  endfunction

  function automatic logic [1:0] dir_dc(input logic [2:0] k);
    logic [1:0] d;
    unique case (k)
      3'd0, 3'd3, 3'd5: d = OFS_NEG;
      3'd1, 3'd6:       d = OFS_ZERO;
      default:          d = OFS_POS;
    endcase
    return d;
  endfunction

endpackage

/* hw/rtl/gne_ram.sv */
// ----------------------------------------------------------------------------
// gne_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module gne_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/gne_ctrl.sv */
// ----------------------------------------------------------------------------
// gne_ctrl: sequencer of the grid neighbor expander
// Steps a write item through read-modify-write of one map row and an
// expand item through three row reads, the mask build and the result walk.
// ----------------------------------------------------------------------------
module gne_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  gne_pkg::dp_status_t status,
  output gne_pkg::dp_cmd_t    cmd
);
  import gne_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.rd_sel     = SEL_MID;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = (status.func == FUNC_WRITE) ? ST_WR_RD : ST_RD_UP;
        end
      end
      ST_WR_RD: begin
        cmd.rd_sel = SEL_MID;
        state_next = ST_WR_WB;
      end
      ST_WR_WB: begin
        cmd.wr_en  = 1'b1;
        state_next = ST_IDLE;
      end
      ST_RD_UP: begin
        cmd.rd_sel = SEL_UP;
        state_next = ST_RD_MID;
      end
      ST_RD_MID: begin
        cmd.rd_sel = SEL_MID;
        cmd.cap_up = 1'b1;
        state_next = ST_RD_DN;
      end
      ST_RD_DN: begin
        cmd.rd_sel  = SEL_DN;
        cmd.cap_mid = 1'b1;
        state_next  = ST_MASK;
      end
      ST_MASK: begin
        cmd.build_mask = 1'b1;
        state_next     = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_can_load) begin
          cmd.emit = 1'b1;
          if (status.emit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* hw/rtl/gne_datapath.sv */
// ----------------------------------------------------------------------------
// gne_datapath: map storage, neighbor checks and result register
// Holds the configuration, the row-wide obstacle map with per-row valid
// flags, the two row buffers, the pending neighbor mask and the result.
// ----------------------------------------------------------------------------
module gne_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  gne_pkg::in_item_t         in_data,
  output gne_pkg::out_item_t        out_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  input  logic                      cfg_we,
  input  logic [gne_pkg::CFG_AW-1:0] cfg_index,
  input  logic [gne_pkg::CFG_DW-1:0] cfg_data,
  input  gne_pkg::dp_cmd_t          cmd,
  output gne_pkg::dp_status_t       status
);
  import gne_pkg::*;

  // Configuration registers.
  logic [6:0] grid_rows;
  logic [6:0] grid_cols;
  logic [5:0] exit_row;
  logic [5:0] exit_col;
  logic       hmode;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= 7'd64;
      grid_cols <= 7'd64;
      exit_row  <= '0;
      exit_col  <= '0;
      hmode     <= HMODE_OCTILE;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_GRID_ROWS: grid_rows <= cfg_data[6:0];
        CFG_GRID_COLS: grid_cols <= cfg_data[6:0];
        CFG_EXIT_ROW:  exit_row  <= cfg_data[5:0];
        CFG_EXIT_COL:  exit_col  <= cfg_data[5:0];
        CFG_HMODE:     hmode     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Captured item.
  logic [5:0] r_q;
  logic [5:0] c_q;
  logic       blk_q;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      r_q   <= in_data.cell_row;
      c_q   <= in_data.cell_col;
      blk_q <= in_data.blocked;
    end
  end

  // Obstacle map: one word per row. A row never written reads as free.
  logic [ROW_AW-1:0]   raddr;
  logic [ROW_AW-1:0]   rd_row_q;
  logic [MAX_COLS-1:0] ram_rdata;
  logic [MAX_COLS-1:0] row_word;
  logic [MAX_COLS-1:0] wr_word;
  logic [MAX_ROWS-1:0] row_vld;

  always_comb begin
    unique case (cmd.rd_sel)
      SEL_UP:  raddr = ROW_AW'(r_q - 6'd1);
      SEL_DN:  raddr = ROW_AW'(r_q + 6'd1);
      default: raddr = ROW_AW'(r_q);
    endcase
  end

  always_ff @(posedge clk) begin
    rd_row_q <= raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
    end else if (cmd.wr_en) begin
      row_vld[ROW_AW'(r_q)] <= 1'b1;
    end
  end

  assign row_word = row_vld[rd_row_q] ? ram_rdata : '0;

  always_comb begin
    wr_word = row_word;
    wr_word[COL_AW'(c_q)] = blk_q;
  end

  gne_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_map (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (ROW_AW'(r_q)),
    .wdata (wr_word),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // Row buffers around the expanded cell; the lower row is taken straight
  // from the RAM output while the mask is built.
  logic [MAX_COLS-1:0] row_up;
  logic [MAX_COLS-1:0] row_mid;

  always_ff @(posedge clk) begin
    if (cmd.cap_up) begin
      row_up <= row_word;
    end
    if (cmd.cap_mid) begin
      row_mid <= row_word;
    end
  end

  logic [6:0] rows_used;
  logic [6:0] cols_used;

  assign rows_used = (grid_rows > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : grid_rows;
  assign cols_used = (grid_cols > 7'(MAX_COLS)) ? 7'(MAX_COLS) : grid_cols;

  function automatic logic [7:0] offset8(input logic [5:0] v, input logic [1:0] d);
    return {2'b00, v} + {{6{d[1]}}, d};
  endfunction

  // One independent check per neighbor.
  logic [7:0] mask;

  always_comb begin
    logic [7:0]          nr8;
    logic [7:0]          nc8;
    logic [MAX_COLS-1:0] nrow;
    logic                inb;
    logic                diag;
    mask = '0;
    for (int k = 0; k < 8; k++) begin
      nr8 = offset8(r_q, dir_dr(3'(k)));
      nc8 = offset8(c_q, dir_dc(3'(k)));
      unique case (dir_dr(3'(k)))
        OFS_NEG:  nrow = row_up;
        OFS_ZERO: nrow = row_mid;
        default:  nrow = row_word;
      endcase
      inb  = !nr8[7] && !nc8[7] && (nr8[6:0] < rows_used) && (nc8[6:0] < cols_used);
      diag = (dir_dr(3'(k)) != OFS_ZERO) && (dir_dc(3'(k)) != OFS_ZERO);
      mask[k] = inb && !nrow[COL_AW'(nc8[5:0])] &&
                !(diag && row_mid[COL_AW'(nc8[5:0])] && nrow[COL_AW'(c_q)]);
    end
  end

  // Pending neighbors, taken lowest first.
  logic [7:0] pend;
  logic [2:0] sel;
  logic [7:0] pend_rest;
  logic       pend_empty;

  always_comb begin
    sel = '0;
    for (int k = 7; k >= 0; k--) begin
      if (pend[k]) begin
        sel = 3'(k);
      end
    end
  end

  assign pend_rest  = pend & ~(8'd1 << sel);
  assign pend_empty = (pend == '0);

  always_ff @(posedge clk) begin
    if (cmd.build_mask) begin
      pend <= mask;
    end else if (cmd.emit) begin
      pend <= pend_rest;
    end
  end

  // Fields of the selected neighbor.
  logic [5:0] sel_r;
  logic [5:0] sel_c;
  logic       sel_diag;
  logic [5:0] dr;
  logic [5:0] dc;
  logic [5:0] hi;
  logic [5:0] lo;
  logic [8:0] heur;

  assign sel_r    = 6'(offset8(r_q, dir_dr(sel)));
  assign sel_c    = 6'(offset8(c_q, dir_dc(sel)));
  assign sel_diag = (dir_dr(sel) != OFS_ZERO) && (dir_dc(sel) != OFS_ZERO);
  assign dr       = (exit_row > sel_r) ? exit_row - sel_r : sel_r - exit_row;
  assign dc       = (exit_col > sel_c) ? exit_col - sel_c : sel_c - exit_col;
  assign hi       = (dr > dc) ? dr : dc;
  assign lo       = (dr > dc) ? dc : dr;

  // Octile 7*lo + 5*(hi - lo) is the same as 5*hi + 2*lo.
  assign heur = (hmode == HMODE_OCTILE) ? (9'(hi) * 9'd5 + 9'(lo) * 9'd2)
                                        : ((9'(dr) + 9'(dc)) * 9'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (pend_empty) begin
        out_data <= '{nbr_row: '0, nbr_col: '0, move_cost: '0, heuristic: '0,
                      found: 1'b0, last: 1'b1};
      end else begin
        out_data <= '{nbr_row: sel_r, nbr_col: sel_c,
                      move_cost: sel_diag ? COST_DIAG : COST_ORTHO,
                      heuristic: heur, found: 1'b1, last: (pend_rest == '0)};
      end
    end
  end

  assign status.func         = in_data.func;
  assign status.out_can_load = !out_valid || out_ready;
  assign status.emit_last    = (pend_rest == '0);

  a_none_found_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.last && out_data.move_cost == '0)
    else $error("empty expansion result is not a lone final result");

  a_found_cost: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.found |->
      out_data.move_cost == COST_ORTHO || out_data.move_cost == COST_DIAG)
    else $error("neighbor result with a bad move cost");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !out_valid || out_ready)
    else $error("result register loaded while a result waits");

  a_row_marked: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |=> row_vld[$past(ROW_AW'(r_q))])
    else $error("written map row not marked valid");

endmodule

/* hw/rtl/grid_neighbor_expander_unit.sv */
// ----------------------------------------------------------------------------
// grid_neighbor_expander_unit: eight-neighbor expansion step for grid search
// Keeps a one-bit obstacle map and lists the free neighbors of a cell with
// move cost and octile or weighted Manhattan distance to the exit.
// ----------------------------------------------------------------------------
// The obstacle map is one RAM word per grid row with a registered read port,
// and the block works on one item at a time. A write item steps through
// accept, row read and row write-back. An expand item steps through accept,
// three row reads (above, at and below the cell), the neighbor mask, then
// the results one by one; there are 1 to 8 results, and a stalled output
// holds the walk. Map rows carry valid flags that reset clears, so the map
// reads as free right after reset with no clearing pass. The next item is
// taken while the final result still sits in the output register.
module grid_neighbor_expander_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  gne_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output gne_pkg::out_item_t         out_data,
  input  logic                       cfg_we,
  input  logic [gne_pkg::CFG_AW-1:0] cfg_index,
  input  logic [gne_pkg::CFG_DW-1:0] cfg_data
);
  import gne_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  gne_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  gne_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

/* sim/grid_neighbor_expander_unit_tb.sv */
// ----------------------------------------------------------------------------
// grid_neighbor_expander_unit_tb: self-checking bench for the neighbor expander
// Drives write and expand items through the valid/ready input channel with
// bursts and gaps, stalls the output channel on its own pattern, and checks
// every result item against a directed expectation or an in-bench model of
// the obstacle map and of the eight-neighbor expansion. A directed table
// comes first, then random items over several register settings.
// ----------------------------------------------------------------------------
module grid_neighbor_expander_unit_tb;
  import gne_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int DIRECTED_LEN   = 23;
  localparam int N_PHASES       = 7;
  localparam int ITEMS_PER_PHASE = 22;

  // Indexes past the last register; writes there must change nothing.
  localparam logic [CFG_AW-1:0] CFG_IDX_PAST_END = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_IDX_SPARE    = 3'd7;

  localparam out_item_t NO_NEIGHBOR = '{6'd0, 6'd0, 3'd0, 9'd0, 1'b0, 1'b1};

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_RANDOM,
    RDY_PERIODIC
  } ready_mode_t;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t result;
  } directed_row_t;

  typedef struct packed {
    logic [6:0] rows;
    logic [6:0] cols;
    logic [6:0] exit_row;
    logic [6:0] exit_col;
    logic [6:0] hmode;
  } cfg_setting_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_we = 1'b0;
  logic [CFG_AW-1:0]   cfg_index = '0;
  logic [CFG_DW-1:0]   cfg_data = '0;

  // Shadow of the block: obstacle map and register values.
  bit         obstacle [0:MAX_ROWS-1][0:MAX_COLS-1];
  logic [6:0] grid_rows = 7'd64;
  logic [6:0] grid_cols = 7'd64;
  logic [5:0] exit_row = 6'd0;
  logic [5:0] exit_col = 6'd0;
  logic       hmode = HMODE_OCTILE;

  out_item_t     neighbor_queue[$];
  int            mismatch_count = 0;
  int            idle_cycles = 0;
  int            burst_left = 0;
  directed_row_t directed_table [DIRECTED_LEN];
  cfg_setting_t  phase_table [N_PHASES];

  grid_neighbor_expander_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  function automatic bit cell_is_blocked(input int r, input int c);
    if (r < 0 || c < 0 || r >= MAX_ROWS || c >= MAX_COLS) begin
      return 1'b0;
    end
    return obstacle[r][c];
  endfunction

  // Applies one accepted item to the shadow map and queues the neighbors it yields.
  task automatic model_grid_item(input in_item_t it);
    int        rows_used, cols_used, k, dr, dc, nr, nc, drow, dcol, hi, lo, h;
    bit        diag;
    out_item_t res;
    out_item_t found_list[$];
    if (it.func == FUNC_WRITE) begin
      obstacle[it.cell_row][it.cell_col] = it.blocked;
      return;
    end
    rows_used = (grid_rows > MAX_ROWS) ? MAX_ROWS : grid_rows;
    cols_used = (grid_cols > MAX_COLS) ? MAX_COLS : grid_cols;
    for (k = 0; k < 8; k++) begin
      dr = (k < 3) ? -1 : (k < 5) ? 0 : 1;
      dc = (k == 0 || k == 3 || k == 5) ? -1 : (k == 1 || k == 6) ? 0 : 1;
      nr = int'(it.cell_row) + dr;
      nc = int'(it.cell_col) + dc;
      diag = (dr != 0) && (dc != 0);
      if (nr < 0 || nc < 0 || nr >= rows_used || nc >= cols_used) continue;
      if (cell_is_blocked(nr, nc)) continue;
      // A diagonal move may not cut between two blocked side cells.
      if (diag && cell_is_blocked(it.cell_row, nc) && cell_is_blocked(nr, it.cell_col)) continue;
      drow = (int'(exit_row) > nr) ? int'(exit_row) - nr : nr - int'(exit_row);
      dcol = (int'(exit_col) > nc) ? int'(exit_col) - nc : nc - int'(exit_col);
      hi = (drow > dcol) ? drow : dcol;
      lo = (drow > dcol) ? dcol : drow;
      if (hmode == HMODE_OCTILE) begin
        h = 7 * lo + 5 * (hi - lo);
      end else begin
        h = 3 * (drow + dcol);
      end
      res.nbr_row   = 6'(nr);
      res.nbr_col   = 6'(nc);
      res.move_cost = diag ? COST_DIAG : COST_ORTHO;
      res.heuristic = 9'(h);
      res.found     = 1'b1;
      res.last      = 1'b0;
      found_list.push_back(res);
    end
    if (found_list.size() == 0) begin
      neighbor_queue.push_back(NO_NEIGHBOR);
    end else begin
      found_list[found_list.size() - 1].last = 1'b1;
      foreach (found_list[i]) neighbor_queue.push_back(found_list[i]);
    end
  endtask

  // Starts at a falling edge and returns at the rising edge that accepts the item.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_res);
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 4))
        @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (typed) begin
      neighbor_queue.push_back(typed_res);
    end else begin
      model_grid_item(it);
    end
  endtask

  // Holds the input off until every expected item has arrived and the block
  // has had time to finish any trailing write.
  task automatic drain_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (neighbor_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Must be called at a falling edge with the block idle.
  task automatic load_settings(input cfg_setting_t s, input logic [CFG_AW-1:0] spare_idx);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GRID_ROWS;
    cfg_data  <= s.rows;
    @(negedge clk);
    cfg_index <= CFG_GRID_COLS;
    cfg_data  <= s.cols;
    @(negedge clk);
    cfg_index <= CFG_EXIT_ROW;
    cfg_data  <= s.exit_row;
    @(negedge clk);
    cfg_index <= CFG_EXIT_COL;
    cfg_data  <= s.exit_col;
    @(negedge clk);
    cfg_index <= CFG_HMODE;
    cfg_data  <= s.hmode;
    @(negedge clk);
    cfg_index <= spare_idx;
    cfg_data  <= ~s.rows;
    @(negedge clk);
    cfg_we <= 1'b0;
    grid_rows = s.rows;
    grid_cols = s.cols;
    exit_row  = s.exit_row[5:0];
    exit_col  = s.exit_col[5:0];
    hmode     = s.hmode[0];
  endtask

  // Output side: stalls follow a randomly drawn mode: always ready, random or periodic.
  int          rdy_cycle = 0;
  ready_mode_t rdy_mode = RDY_ALWAYS;

  always @(negedge clk) begin
    if (rdy_cycle % 64 == 0) begin
      rdy_mode = ready_mode_t'($urandom_range(0, 2));
    end
    case (rdy_mode)
      RDY_ALWAYS: out_ready <= 1'b1;
      RDY_RANDOM: out_ready <= 1'($urandom_range(0, 1));
      default:    out_ready <= (rdy_cycle % 7) >= 3;
    endcase
    rdy_cycle++;
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (out_valid && out_ready) begin
        if (neighbor_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected item %h", out_data));
        end else begin
          want = neighbor_queue.pop_front();
          check_field("nbr_row", out_data.nbr_row, want.nbr_row);
          check_field("nbr_col", out_data.nbr_col, want.nbr_col);
          check_field("move_cost", out_data.move_cost, want.move_cost);
          check_field("heuristic", out_data.heuristic, want.heuristic);
          check_field("found", out_data.found, want.found);
          check_field("last", out_data.last, want.last);
        end
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles with no item accepted", WATCHDOG_LIMIT);
    $display("grid_neighbor_expander_unit test failed");
    $finish;
  end

  initial begin
    in_item_t it;
    int       row_base, col_base;

    // Reset values apply here: 64 x 64 grid, exit at the origin, octile.
    directed_table = '{
      '{'{FUNC_EXPAND, 6'd0,  6'd0,  1'b0}, 1'b0, '0},
      '{'{FUNC_EXPAND, 6'd63, 6'd63, 1'b1}, 1'b0, '0},
      '{'{FUNC_EXPAND, 6'd32, 6'd32, 1'b0}, 1'b0, '0},
      '{'{FUNC_WRITE,  6'd10, 6'd10, 1'b1}, 1'b0, '0},
      '{'{FUNC_WRITE,  6'd10, 6'd11, 1'b1}, 1'b0, '0},
      '{'{FUNC_WRITE,  6'd10, 6'd12, 1'b1}, 1'b0, '0},
      '{'{FUNC_WRITE,  6'd11, 6'd10, 1'b1}, 1'b0, '0},
      '{'{FUNC_WRITE,  6'd11, 6'd12, 1'b1}, 1'b0, '0},
      '{'{FUNC_WRITE,  6'd12, 6'd10, 1'b1}, 1'b0, '0},
      '{'{FUNC_WRITE,  6'd12, 6'd11, 1'b1}, 1'b0, '0},
      '{'{FUNC_WRITE,  6'd12, 6'd12, 1'b1}, 1'b0, '0},
      '{'{FUNC_EXPAND, 6'd11, 6'd11, 1'b0}, 1'b1, NO_NEIGHBOR},
      // The freed corner is still cut off by its two blocked side cells.
      '{'{FUNC_WRITE,  6'd10, 6'd10, 1'b0}, 1'b0, '0},
      '{'{FUNC_EXPAND, 6'd11, 6'd11, 1'b1}, 1'b1, NO_NEIGHBOR},
      '{'{FUNC_WRITE,  6'd10, 6'd11, 1'b0}, 1'b0, '0},
      '{'{FUNC_EXPAND, 6'd11, 6'd11, 1'b0}, 1'b0, '0},
      '{'{FUNC_WRITE,  6'd0,  6'd1,  1'b1}, 1'b0, '0},
      '{'{FUNC_WRITE,  6'd1,  6'd0,  1'b1}, 1'b0, '0},
      '{'{FUNC_EXPAND, 6'd0,  6'd0,  1'b0}, 1'b1, NO_NEIGHBOR},
      '{'{FUNC_EXPAND, 6'd63, 6'd0,  1'b0}, 1'b0, '0},
      '{'{FUNC_EXPAND, 6'd0,  6'd63, 1'b0}, 1'b0, '0},
      '{'{FUNC_WRITE,  6'd63, 6'd63, 1'b1}, 1'b0, '0},
      '{'{FUNC_EXPAND, 6'd62, 6'd62, 1'b0}, 1'b0, '0}
    };

    // Out-of-range sizes and exit coordinates rely on the block's masking.
    phase_table = '{
      '{7'd64,  7'd64,  7'd63,  7'd63,  7'd0},
      '{7'd8,   7'd5,   7'd3,   7'd2,   7'd1},
      '{7'd1,   7'd1,   7'd0,   7'd0,   7'd0},
      '{7'd0,   7'd64,  7'h7F,  7'h7F,  7'h7F},
      '{7'h7F,  7'd100, 7'd17,  7'd45,  7'd1},
      '{7'd2,   7'd64,  7'd1,   7'd40,  7'd0},
      '{7'd64,  7'd2,   7'd50,  7'd1,   7'd1}
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_table[i]) begin
      send_item(directed_table[i].item, directed_table[i].typed, directed_table[i].result);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      drain_block();
      load_settings(phase_table[p], (p % 2 == 1) ? CFG_IDX_SPARE : CFG_IDX_PAST_END);
      // Small grids keep the cells near the origin so that expansions find
      // edges and obstacles; large ones work in a window that may wrap.
      row_base = (grid_rows < 16) ? 0 : $urandom_range(0, 63);
      col_base = (grid_cols < 16) ? 0 : $urandom_range(0, 63);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        it.func = ($urandom_range(0, 99) < 45) ? FUNC_EXPAND : FUNC_WRITE;
        if ($urandom_range(0, 7) == 0) begin
          it.cell_row = 6'($urandom_range(0, 63));
          it.cell_col = 6'($urandom_range(0, 63));
        end else begin
          it.cell_row = 6'(row_base + $urandom_range(0, 9));
          it.cell_col = 6'(col_base + $urandom_range(0, 9));
        end
        it.blocked = ($urandom_range(0, 9) < 6);
        send_item(it, 1'b0, '0);
        if ($urandom_range(0, 39) == 0) begin
          drain_block();
        end
      end
    end

    drain_block();
    if (mismatch_count == 0) begin
      $display("grid_neighbor_expander_unit test passed");
    end else begin
      $display("grid_neighbor_expander_unit test failed");
    end
    $finish;
  end

endmodule
